@@ design/cfcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framed
// command receiver.
// ----------------------------------------------------------------------------
package cfcr_pkg;

  localparam int unsigned MAX_PAYLOAD = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned HEAD_BYTES  = 4;

  localparam logic [7:0]  HEAD_FIRST  = 8'hAA;
  localparam logic [7:0]  HEAD_SECOND = 8'h55;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [15:0]      TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]       CMD_RESET     = 8'h01;
  localparam logic [LEN_W-1:0] LEN_RESET     = 5'd4;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEAD2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_SEQ     = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRCLO   = 3'd6,
    PH_CRCHI   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OK       = 3'd1,
    EV_CRC      = 3'd2,
    EV_OVERSIZE = 3'd3,
    EV_WRONG    = 3'd4,
    EV_OFFLINE  = 3'd5
  } event_t;

  // frame outcome handed from the parser to the link logic
  typedef struct packed {
    logic        good;
    logic        crc_err;
    logic        oversize;
    logic        wrong;
    logic [7:0]  sequence_val;
    logic [15:0] speed;
    logic [15:0] turn;
  } frame_status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/cfcr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_parser
// Frame parser: header hunt, field capture, running CRC and frame verdict.
// ----------------------------------------------------------------------------
module cfcr_parser import cfcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_en,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       control_command,
  input  logic [LEN_W-1:0] control_length,
  output frame_status_t    status
);

  phase_t           phase, phase_next;
  logic [7:0]       frame_command, frame_command_next;
  logic [7:0]       frame_sequence, frame_sequence_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] payload_position, payload_position_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       crc_low_byte, crc_low_byte_next;
  logic [7:0]       payload_head [HEAD_BYTES];
  logic             head_we;
  logic             frame_end;
  logic [15:0]      crc_upd;

  assign crc_upd = crc_feed(running_crc, rx_byte);

  always_comb begin
    phase_next            = phase;
    frame_command_next    = frame_command;
    frame_sequence_next   = frame_sequence;
    frame_length_next     = frame_length;
    payload_position_next = payload_position;
    running_crc_next      = running_crc;
    crc_low_byte_next     = crc_low_byte;
    head_we               = 1'b0;
    frame_end             = 1'b0;
    status                = '0;
    status.sequence_val   = frame_sequence;
    status.speed          = {payload_head[1], payload_head[0]};
    status.turn           = {payload_head[3], payload_head[2]};
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == HEAD_FIRST) phase_next = PH_HEAD2;
      end
      PH_HEAD2: begin
        phase_next = (rx_byte == HEAD_SECOND) ? PH_CMD : PH_HUNT;
      end
      PH_CMD: begin
        frame_command_next = rx_byte;
        running_crc_next   = crc_upd;
        phase_next         = PH_SEQ;
      end
      PH_SEQ: begin
        frame_sequence_next = rx_byte;
        running_crc_next    = crc_upd;
        phase_next          = PH_LEN;
      end
      PH_LEN: begin
        payload_position_next = '0;
        if (rx_byte > 8'(MAX_PAYLOAD)) begin
          status.oversize = 1'b1;
          frame_end       = 1'b1;
        end else begin
          frame_length_next = rx_byte[LEN_W-1:0];
          running_crc_next  = crc_upd;
          phase_next        = (rx_byte == 8'h00) ? PH_CRCLO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        head_we               = (payload_position < LEN_W'(HEAD_BYTES));
        running_crc_next      = crc_upd;
        payload_position_next = payload_position + LEN_W'(1);
        if (payload_position_next >= frame_length) phase_next = PH_CRCLO;
      end
      PH_CRCLO: begin
        crc_low_byte_next = rx_byte;
        phase_next        = PH_CRCHI;
      end
      PH_CRCHI: begin
        frame_end = 1'b1;
        if ({rx_byte, crc_low_byte} != running_crc) begin
          status.crc_err = 1'b1;
        end else if (frame_command != control_command ||
                     frame_length != control_length) begin
          status.wrong = 1'b1;
        end else begin
          status.good = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
    // back to hunting with a fresh parser context
    if (frame_end) begin
      phase_next            = PH_HUNT;
      frame_command_next    = '0;
      frame_sequence_next   = '0;
      frame_length_next     = '0;
      payload_position_next = '0;
      running_crc_next      = CRC_INIT;
      crc_low_byte_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      frame_command    <= '0;
      frame_sequence   <= '0;
      frame_length     <= '0;
      payload_position <= '0;
      running_crc      <= CRC_INIT;
      crc_low_byte     <= '0;
    end else if (byte_en) begin
      phase            <= phase_next;
      frame_command    <= frame_command_next;
      frame_sequence   <= frame_sequence_next;
      frame_length     <= frame_length_next;
      payload_position <= payload_position_next;
      running_crc      <= running_crc_next;
      crc_low_byte     <= crc_low_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && head_we) begin
      payload_head[payload_position[1:0]] <= rx_byte;
    end
  end

endmodule

@@ design/crc16_framed_command_receiver_top.sv @@
`timescale 1ns / 1ps
// path: an accepted request waits in the input register until the result slot
//   frees; parsing and the byte-wide crc update sit between it and the
//   link state / result registers, which take the result at that point
// throughput: one request per cycle unless the result output stalls
// reset: synchronous, active high; parser returns to header hunt, link goes
//   offline, counters and speeds clear, config returns to its defaults
// ----------------------------------------------------------------------------
// crc16_framed_command_receiver_top
// Framed command receiver with CRC-16/MODBUS check and link timeout.
// ----------------------------------------------------------------------------
module crc16_framed_command_receiver_top import cfcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  s_tuser,   // [0] mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] velocity_x, [31:16] turn_rate, [39:32] sequence_res, [40] online,
  // [72:41] frames_ok, [104:73] crc_errors, [136:105] drops, [143:137] zero
  output logic [143:0]          m_tdata,
  output logic [2:0]            m_tuser,   // [2:0] event_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0]      link_timeout;
  logic [7:0]       control_command;
  logic [LEN_W-1:0] control_length;

  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;

  frame_status_t status;

  logic [15:0] speed_reg, speed_next;
  logic [15:0] turn_reg, turn_next;
  logic [7:0]  sequence_reg, sequence_next;
  logic        online_flag, online_next;
  logic [15:0] elapsed_ms, elapsed_next, elapsed_inc;
  logic [31:0] ok_count, ok_count_next;
  logic [31:0] crc_fail_count, crc_fail_count_next;
  logic [31:0] discard_count, discard_count_next;
  event_t      event_reg, event_next;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      link_timeout    <= TIMEOUT_RESET;
      control_command <= CMD_RESET;
      control_length  <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: link_timeout    <= cfg_data;
        CFG_COMMAND: control_command <= cfg_data[7:0];
        CFG_LENGTH:  control_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  cfcr_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .byte_en         (fire && !in_mode),
    .rx_byte         (in_byte),
    .control_command (control_command),
    .control_length  (control_length),
    .status          (status)
  );

  assign elapsed_inc = (elapsed_ms == 16'hFFFF) ? elapsed_ms : elapsed_ms + 16'd1;

  always_comb begin
    speed_next          = speed_reg;
    turn_next           = turn_reg;
    sequence_next       = sequence_reg;
    online_next         = online_flag;
    elapsed_next        = elapsed_ms;
    ok_count_next       = ok_count;
    crc_fail_count_next = crc_fail_count;
    discard_count_next  = discard_count;
    event_next          = EV_NONE;
    if (in_mode) begin
      elapsed_next = elapsed_inc;
      if (online_flag && elapsed_inc > link_timeout) begin
        online_next = 1'b0;
        speed_next  = '0;
        turn_next   = '0;
        event_next  = EV_OFFLINE;
      end
    end else if (status.good) begin
      speed_next    = status.speed;
      turn_next     = status.turn;
      sequence_next = status.sequence_val;
      online_next   = 1'b1;
      elapsed_next  = '0;
      ok_count_next = ok_count + 32'd1;
      event_next    = EV_OK;
    end else if (status.crc_err) begin
      crc_fail_count_next = crc_fail_count + 32'd1;
      event_next          = EV_CRC;
    end else if (status.oversize) begin
      discard_count_next = discard_count + 32'd1;
      event_next         = EV_OVERSIZE;
    end else if (status.wrong) begin
      discard_count_next = discard_count + 32'd1;
      event_next         = EV_WRONG;
    end
  end

  // link state doubles as the result register: it only moves when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_reg      <= '0;
      turn_reg       <= '0;
      sequence_reg   <= '0;
      online_flag    <= 1'b0;
      elapsed_ms     <= '0;
      ok_count       <= '0;
      crc_fail_count <= '0;
      discard_count  <= '0;
      event_reg      <= EV_NONE;
      m_tvalid       <= 1'b0;
    end else begin
      if (fire) begin
        speed_reg      <= speed_next;
        turn_reg       <= turn_next;
        sequence_reg   <= sequence_next;
        online_flag    <= online_next;
        elapsed_ms     <= elapsed_next;
        ok_count       <= ok_count_next;
        crc_fail_count <= crc_fail_count_next;
        discard_count  <= discard_count_next;
        event_reg      <= event_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = event_reg;
  assign m_tdata = {7'd0, discard_count, crc_fail_count, ok_count, online_flag,
                    sequence_reg, turn_reg, speed_reg};

endmodule

@@ design/cfcr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_checker
// Port-level checks on the receiver's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cfcr_checker import cfcr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [143:0]          m_tdata,
  input logic [2:0]            m_tuser
);

  // offline means no speed command is held
  a_offline_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[40]) |-> (m_tdata[31:0] == 32'd0))
    else $error("speeds nonzero while offline");

  a_ok_online: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_OK) |-> m_tdata[40])
    else $error("accepted frame without online");

  a_offline_event: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_OFFLINE) |-> !m_tdata[40])
    else $error("offline event while still online");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind crc16_framed_command_receiver_top cfcr_checker u_cfcr_checker (.*);
